// File: rtl/core/ddw_pkg.sv
// Shared types, calendar tables and constants for the date difference and weekday block.
package ddw_pkg;

    // Field widths
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DNUM_W  = 23;
    localparam int WDAY_W  = 3;

    // Calendar constants
    localparam int DAYS_PER_YEAR = 365;
    localparam int WEEK_DAYS     = 7;
    localparam int FEBRUARY      = 2;
    localparam int DECEMBER      = 12;

    // Reference Sunday 2013-01-06 has day number 735240, which is 2 mod 7
    localparam int REF_DAY_MOD7  = 2;
    localparam logic [WDAY_W-1:0] REF_SHIFT = WDAY_W'(WEEK_DAYS - REF_DAY_MOD7);

    // Reciprocal for x / 100: (x * 5243) >> 19 is exact for x below 43699
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int          RECIP_SH  = 19;

    // Days before each month, and month lengths (common year); unused codes are zero
    localparam logic [8:0] DAYS_BEFORE [16] = '{
        9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd0, 9'd0, 9'd0
    };
    localparam logic [4:0] MONTH_LEN [16] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
    };

    // Result of one lane: day number and calendar error flag
    typedef struct packed {
        logic [DNUM_W-1:0] dnum;
        logic              bad;
    } ddw_day_t;

endpackage

// File: rtl/core/ddw_day_lane.sv
// One date lane: clamps the year and turns a date into its day number and error flag over three stages.
module ddw_day_lane #(
    parameter int MAX_YEAR = 9999
) (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [ddw_pkg::YEAR_W-1:0]  year,
    input  logic [ddw_pkg::MONTH_W-1:0] month,
    input  logic [ddw_pkg::DAY_W-1:0]   day,
    output ddw_pkg::ddw_day_t           res
);
    import ddw_pkg::*;

    localparam logic [15:0] MAX_Y16 = 16'(MAX_YEAR);

    // floor(x / 100) by reciprocal multiply
    function automatic logic [7:0] div100(input logic [14:0] x);
        logic [27:0] p;
        begin
            p = 28'(x) * 28'(RECIP_100);
            div100 = 8'(p >> RECIP_SH);
        end
    endfunction

    // Stage 1: year clamp
    logic [YEAR_W-1:0]  y1_reg, y1_next;
    logic [MONTH_W-1:0] m1_reg;
    logic [DAY_W-1:0]   d1_reg;

    always_comb begin
        if ({2'b00, year} > MAX_Y16) begin
            y1_next = MAX_Y16[YEAR_W-1:0];
        end else begin
            y1_next = year;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y1_reg <= y1_next;
            m1_reg <= month;
            d1_reg <= day;
        end
    end

    // Stage 2: century and quad-century quotients
    logic [YEAR_W-1:0]  y2_reg;
    logic [MONTH_W-1:0] m2_reg;
    logic [DAY_W-1:0]   d2_reg;
    logic [7:0]         q_cent_reg, q_cent_next;  // y / 100
    logic [7:0]         q_adj_reg, q_adj_next;    // (y + 99) / 100
    logic [7:0]         q_400_reg, q_400_next;    // (y + 399) / 400
    logic [14:0]        y_p399;

    always_comb begin
        y_p399      = 15'(y1_reg) + 15'd399;
        q_cent_next = div100(15'(y1_reg));
        q_adj_next  = div100(15'(y1_reg) + 15'd99);
        q_400_next  = div100(15'(y_p399 >> 2));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y2_reg     <= y1_reg;
            m2_reg     <= m1_reg;
            d2_reg     <= d1_reg;
            q_cent_reg <= q_cent_next;
            q_adj_reg  <= q_adj_next;
            q_400_reg  <= q_400_next;
        end
    end

    // Stage 3: leap rule, month check and day number
    ddw_day_t   res_reg, res_next;
    logic       cent_zero, leap, m_ok, leap_feb, leap_add;
    logic [4:0] mlen;

    always_comb begin
        cent_zero = (y2_reg == YEAR_W'(14'(q_cent_reg) * 14'd100));
        leap      = ((y2_reg[1:0] == 2'b00) && !cent_zero)
                  || (cent_zero && (q_cent_reg[1:0] == 2'b00));
        m_ok      = (m2_reg >= MONTH_W'(1)) && (m2_reg <= MONTH_W'(DECEMBER));
        leap_feb  = leap && (m2_reg == MONTH_W'(FEBRUARY));
        leap_add  = leap && m_ok && (m2_reg > MONTH_W'(FEBRUARY));
        mlen      = MONTH_LEN[m2_reg] + {4'b0000, leap_feb};

        res_next.bad  = !m_ok || (d2_reg == '0) || (d2_reg > mlen);
        res_next.dnum = DNUM_W'(DNUM_W'(y2_reg) * DNUM_W'(DAYS_PER_YEAR))
                      + DNUM_W'((15'(y2_reg) + 15'd3) >> 2)
                      - DNUM_W'(q_adj_reg)
                      + DNUM_W'(q_400_reg)
                      + DNUM_W'(DAYS_BEFORE[m2_reg])
                      + DNUM_W'(leap_add)
                      + DNUM_W'(d2_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// File: rtl/core/ddw_merge.sv
// Merge stage: day difference, weekdays of both dates and the combined error flag.
module ddw_merge (
    input  logic                        aclk,
    input  logic                        en,
    input  ddw_pkg::ddw_day_t           lane_a,
    input  ddw_pkg::ddw_day_t           lane_b,
    output logic [ddw_pkg::DNUM_W-1:0]  day_difference,
    output logic [ddw_pkg::WDAY_W-1:0]  weekday_a,
    output logic [ddw_pkg::WDAY_W-1:0]  weekday_b,
    output logic                        date_invalid
);
    import ddw_pkg::*;

    // Weekday from day number: mod 7 by folding octal digits, then shift to reference
    function automatic logic [WDAY_W-1:0] weekday(input logic [DNUM_W-1:0] n);
        logic [5:0] s1;
        logic [3:0] s2;
        logic [3:0] s3;
        logic [2:0] r;
        logic [3:0] w;
        begin
            s1 = 6'(n[22:21]);
            for (int i = 0; i < 7; i++) begin
                s1 = s1 + 6'(n[3*i +: 3]);
            end
            s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
            s3 = 4'(s2[3]) + 4'(s2[2:0]);
            r  = (s3 == 4'(WEEK_DAYS)) ? 3'd0 : s3[2:0];
            w  = 4'(r) + 4'(REF_SHIFT);
            weekday = (w >= 4'(WEEK_DAYS)) ? 3'(w - 4'(WEEK_DAYS)) : w[2:0];
        end
    endfunction

    logic [DNUM_W-1:0] diff_reg;
    logic [WDAY_W-1:0] wa_reg, wb_reg;
    logic              bad_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            diff_reg <= lane_b.dnum - lane_a.dnum;
            wa_reg   <= weekday(lane_a.dnum);
            wb_reg   <= weekday(lane_b.dnum);
            bad_reg  <= lane_a.bad || lane_b.bad;
        end
    end

    assign day_difference = diff_reg;
    assign weekday_a      = wa_reg;
    assign weekday_b      = wb_reg;
    assign date_invalid   = bad_reg;

endmodule

// File: rtl/core/date_difference_weekday.sv
// Top level: two date lanes, merge stage and stream handshake.
//
// Usage:
//   Slave channel s_* takes one word per date pair (A and B). Master channel
//   m_* gives one word per pair: signed day difference B minus A, weekday of
//   each date (0 Sunday) in tdata, and a calendar error flag in tuser.
//   Pipeline: three lane stages for year clamp, century quotients and day
//   number, then one merge stage, from input acceptance to m_tvalid.
//   Throughput: one word per cycle while not stalled; the two dates run in separate lanes.
//   Stall: the whole pipeline holds while m_tvalid is high and m_tready is
//   low; s_tready drops in the same cycle and no word is lost or repeated.
//   Reset: synchronous, active low aresetn empties the pipeline; no words
//   are in flight afterward. Years above MAX_YEAR are clamped to MAX_YEAR.
module date_difference_weekday #(
    parameter int MAX_YEAR = 9999
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // year_a[13:0], month_a[17:14], day_a[22:18], year_b[36:23], month_b[40:37],
    // day_b[45:41], zero[47:46]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // day_difference[22:0], weekday_a[25:23], weekday_b[28:26], zero[31:29]
    output logic [31:0] m_tdata,
    // date_invalid[0]
    output logic        m_tuser
);
    import ddw_pkg::*;

    localparam int STAGES = 4;

    logic              en;
    logic [STAGES-1:0] vld_reg, vld_next;
    ddw_day_t          day_a, day_b;
    logic [DNUM_W-1:0] diff;
    logic [WDAY_W-1:0] wd_a, wd_b;
    logic              bad;

    // Pipeline advances whenever the output slot is free or being taken
    assign en       = m_tready || !m_tvalid;
    assign s_tready = en;
    assign m_tvalid = vld_reg[STAGES-1];

    always_comb begin
        vld_next = {vld_reg[STAGES-2:0], s_tvalid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    // Lanes for dates A and B
    ddw_day_lane #(.MAX_YEAR(MAX_YEAR)) u_lane_a (
        .aclk  (aclk),
        .en    (en),
        .year  (s_tdata[13:0]),
        .month (s_tdata[17:14]),
        .day   (s_tdata[22:18]),
        .res   (day_a)
    );

    ddw_day_lane #(.MAX_YEAR(MAX_YEAR)) u_lane_b (
        .aclk  (aclk),
        .en    (en),
        .year  (s_tdata[36:23]),
        .month (s_tdata[40:37]),
        .day   (s_tdata[45:41]),
        .res   (day_b)
    );

    // Merge and output register
    ddw_merge u_merge (
        .aclk           (aclk),
        .en             (en),
        .lane_a         (day_a),
        .lane_b         (day_b),
        .day_difference (diff),
        .weekday_a      (wd_a),
        .weekday_b      (wd_b),
        .date_invalid   (bad)
    );

    assign m_tdata = {3'b000, wd_b, wd_a, diff};
    assign m_tuser = bad;

endmodule
